// File: rtl/flat_field_cell_offset_lookup_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the flat-field cell offset lookup
// Shared helpers for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef FLAT_FIELD_CELL_OFFSET_LOOKUP_MACROS_SVH
`define FLAT_FIELD_CELL_OFFSET_LOOKUP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define FFCOL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define FFCOL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/ffcol_pkg.sv
// ----------------------------------------------------------------------------
// ffcol_pkg
// Types and constants shared by the flat-field cell offset lookup modules.
// ----------------------------------------------------------------------------
`default_nettype none
package ffcol_pkg;

	localparam int MAX_IMAGES     = 16;
	localparam int SLOT_W         = 4;
	localparam int ID_W           = 8;
	localparam int ID_SPACE       = 256;
	localparam int CELL_W         = 4;
	localparam int NCELL_W        = 5;
	localparam int MAX_CELLS_AXIS = 16;
	localparam int OFF_W          = 16;
	localparam int POS_W          = 16;
	localparam int DIM_W          = 16;
	localparam int CNT_W          = 5;
	localparam int NUM_W          = 20;
	localparam int ADDR_W         = SLOT_W + 2 * CELL_W;

	// binning pads
	localparam logic signed [POS_W:0] PAD_X = 17'sd8;
	localparam logic signed [POS_W:0] PAD_Y = 17'sd10;

	typedef enum logic [1:0] {
		ACT_LOAD_IMAGE,
		ACT_LOAD_CORR,
		ACT_QUERY,
		ACT_NONE
	} action_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_DUP,
		ST_UNKNOWN,
		ST_FULL,
		ST_CELL
	} status_t;

	// classified command passed from front to back
	typedef struct packed {
		action_t                   action;
		status_t                   status;
		logic [SLOT_W-1:0]         slot;
		logic signed [POS_W-1:0]   pixel_x;
		logic signed [POS_W-1:0]   pixel_y;
		logic [NCELL_W-1:0]        cells_across;
		logic [NCELL_W-1:0]        cells_down;
		logic [DIM_W-1:0]          chip_width;
		logic [DIM_W-1:0]          chip_height;
		logic [CELL_W-1:0]         cell_col;
		logic [CELL_W-1:0]         cell_row;
		logic signed [OFF_W-1:0]   offset_value;
	} cmd_t;

endpackage
`default_nettype wire

// File: rtl/ffcol_front.sv
// ----------------------------------------------------------------------------
// ffcol_front
// Accepts items, resolves the image ID map, allocates slots for new images
// and classifies each item into a command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module ffcol_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 clearing,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [111:0]         s_tdata,
	input  wire logic [1:0]           s_tuser,
	output logic                      push_valid,
	input  wire logic                 push_full,
	output ffcol_pkg::cmd_t           push_cmd
);

	typedef enum logic {F_IDLE, F_LOOK} fstate_t;

	fstate_t                         state_q;
	ffcol_pkg::cmd_t                 in_q;
	logic [ffcol_pkg::ID_W-1:0]      id_q;
	logic [ffcol_pkg::ID_SPACE-1:0]  id_valid_q;
	logic [ffcol_pkg::SLOT_W-1:0]    map_mem [ffcol_pkg::ID_SPACE];
	logic [ffcol_pkg::SLOT_W-1:0]    map_rd_q;
	logic [ffcol_pkg::CNT_W-1:0]     count_q;
	logic                            known;
	logic                            geo_bad;
	logic                            alloc;
	ffcol_pkg::status_t              status;

	assign s_tready = (state_q == F_IDLE) && !clearing;

	// classification of the held item
	always_comb begin
		known   = id_valid_q[id_q];
		geo_bad = (in_q.cells_across == '0) ||
			(in_q.cells_across > ffcol_pkg::NCELL_W'(ffcol_pkg::MAX_CELLS_AXIS)) ||
			(in_q.cells_down == '0) ||
			(in_q.cells_down > ffcol_pkg::NCELL_W'(ffcol_pkg::MAX_CELLS_AXIS)) ||
			(in_q.chip_width == '0) || (in_q.chip_height == '0);
		status = ffcol_pkg::ST_OK;
		case (in_q.action)
			ffcol_pkg::ACT_LOAD_IMAGE: begin
				if (known)
					status = ffcol_pkg::ST_DUP;
				else if (count_q >= ffcol_pkg::CNT_W'(ffcol_pkg::MAX_IMAGES))
					status = ffcol_pkg::ST_FULL;
				else if (geo_bad)
					status = ffcol_pkg::ST_CELL;
			end
			ffcol_pkg::ACT_LOAD_CORR, ffcol_pkg::ACT_QUERY: begin
				if (!known)
					status = ffcol_pkg::ST_UNKNOWN;
			end
			default: status = ffcol_pkg::ST_OK;
		endcase
		alloc = (in_q.action == ffcol_pkg::ACT_LOAD_IMAGE) && (status == ffcol_pkg::ST_OK);
		push_cmd        = in_q;
		push_cmd.status = status;
		push_cmd.slot   = alloc ? count_q[ffcol_pkg::SLOT_W-1:0] : map_rd_q;
	end

	assign push_valid = (state_q == F_LOOK);

	// ID map memory: registered read on accept, write on slot allocation
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			map_rd_q <= map_mem[s_tdata[7:0]];
		if (push_valid && !push_full && alloc)
			map_mem[id_q] <= count_q[ffcol_pkg::SLOT_W-1:0];
	end

	// input capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			id_q                <= s_tdata[7:0];
			in_q.action         <= ffcol_pkg::action_t'(s_tuser);
			in_q.status         <= ffcol_pkg::ST_OK;
			in_q.slot           <= '0;
			in_q.pixel_x        <= s_tdata[23:8];
			in_q.pixel_y        <= s_tdata[39:24];
			in_q.cells_across   <= s_tdata[44:40];
			in_q.cells_down     <= s_tdata[49:45];
			in_q.chip_width     <= s_tdata[65:50];
			in_q.chip_height    <= s_tdata[81:66];
			in_q.cell_col       <= s_tdata[85:82];
			in_q.cell_row       <= s_tdata[89:86];
			in_q.offset_value   <= s_tdata[105:90];
		end
	end

	// control: state, valid bits, image count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_IDLE;
			id_valid_q <= '0;
			count_q    <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (s_tvalid && s_tready)
						state_q <= F_LOOK;
				end
				F_LOOK: begin
					if (!push_full) begin
						state_q <= F_IDLE;
						if (alloc) begin
							id_valid_q[id_q] <= 1'b1;
							count_q          <= count_q + 1'b1;
						end
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/ffcol_queue.sv
// ----------------------------------------------------------------------------
// ffcol_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none
module ffcol_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	output logic                 push_full,
	input  wire ffcol_pkg::cmd_t push_cmd,
	output logic                 pop_valid,
	input  wire logic            pop,
	output ffcol_pkg::cmd_t      pop_cmd
);

	ffcol_pkg::cmd_t entry_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      fill_q;
	logic            do_push;
	logic            do_pop;

	assign push_full = (fill_q == 2'd2);
	assign pop_valid = (fill_q != 2'd0);
	assign pop_cmd   = entry_q[rd_ptr_q];
	assign do_push   = push_valid && !push_full;
	assign do_pop    = pop && pop_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push)
				wr_ptr_q <= !wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop)
				fill_q <= fill_q + 2'd1;
			else if (do_pop && !do_push)
				fill_q <= fill_q - 2'd1;
		end
	end

endmodule
`default_nettype wire

// File: rtl/ffcol_div.sv
// ----------------------------------------------------------------------------
// ffcol_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ffcol_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [ffcol_pkg::NUM_W-1:0]   num,
	input  wire logic [ffcol_pkg::DIM_W-1:0]   den,
	output logic                               done,
	output logic [ffcol_pkg::NUM_W-1:0]        quot
);

	logic [ffcol_pkg::NUM_W-1:0] num_q;
	logic [ffcol_pkg::DIM_W-1:0] rem_q;
	logic [ffcol_pkg::DIM_W-1:0] den_q;
	logic [4:0]                  cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [ffcol_pkg::DIM_W:0]   rem_sh;
	logic [ffcol_pkg::DIM_W:0]   rem_sub;
	logic                        qbit;

	// one trial subtraction
	always_comb begin
		rem_sh  = {rem_q, num_q[ffcol_pkg::NUM_W-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		qbit    = (rem_sh >= {1'b0, den_q});
	end

	assign done = done_q;
	assign quot = num_q;

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[ffcol_pkg::NUM_W-2:0], qbit};
			rem_q <= qbit ? rem_sub[ffcol_pkg::DIM_W-1:0] : rem_sh[ffcol_pkg::DIM_W-1:0];
		end
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(ffcol_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/ffcol_back.sv
// ----------------------------------------------------------------------------
// ffcol_back
// Executes classified commands: stores geometry, writes cell offsets, bins
// query pixels with two dividers and looks up the cell offset.
// ----------------------------------------------------------------------------
`default_nettype none
module ffcol_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	output logic                 clearing,
	input  wire logic            pop_valid,
	output logic                 pop,
	input  wire ffcol_pkg::cmd_t pop_cmd,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [23:0]          m_tdata,
	output logic [7:0]           m_tuser
);

	typedef enum logic [2:0] {B_IDLE, B_CHECK, B_DIV, B_READ, B_EMIT} bstate_t;

	localparam int NSLOT = ffcol_pkg::MAX_IMAGES;
	localparam int DEPTH = 1 << ffcol_pkg::ADDR_W;

	bstate_t                              state_q;
	ffcol_pkg::cmd_t                      cur_q;
	logic [ffcol_pkg::NCELL_W-1:0]        geo_nx_q [NSLOT];
	logic [ffcol_pkg::NCELL_W-1:0]        geo_ny_q [NSLOT];
	logic [ffcol_pkg::DIM_W-1:0]          geo_dx_q [NSLOT];
	logic [ffcol_pkg::DIM_W-1:0]          geo_dy_q [NSLOT];
	logic [ffcol_pkg::OFF_W-1:0]          cell_mem [DEPTH];
	logic [ffcol_pkg::OFF_W-1:0]          mem_rd_q;
	logic                                 clr_busy_q;
	logic [ffcol_pkg::ADDR_W-1:0]         clr_addr_q;
	logic                                 neg_x_q;
	logic                                 neg_y_q;
	logic [ffcol_pkg::CELL_W-1:0]         col_q;
	logic [ffcol_pkg::CELL_W-1:0]         row_q;
	ffcol_pkg::status_t                   res_status_q;
	logic                                 res_mem_q;
	logic                                 m_tvalid_q;
	logic [23:0]                          m_tdata_q;
	logic [2:0]                           m_tuser_q;

	logic [ffcol_pkg::NCELL_W-1:0]        nx, ny;
	logic [ffcol_pkg::DIM_W-1:0]          dx, dy;
	logic signed [ffcol_pkg::POS_W:0]     sx, sy;
	logic signed [22:0]                   px, py;
	logic                                 div_start;
	logic                                 dx_done, dy_done;
	logic [ffcol_pkg::NUM_W-1:0]          qx, qy;
	logic [ffcol_pkg::CELL_W-1:0]         col_c, row_c;
	logic [ffcol_pkg::NCELL_W-1:0]        nx_m1, ny_m1;
	logic                                 in_grid;
	logic                                 wr_corr;
	logic                                 out_free;

	assign clearing = clr_busy_q;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = {5'd0, m_tuser_q};
	assign out_free = !m_tvalid_q || m_tready;
	assign pop      = (state_q == B_IDLE) && pop_valid && !clr_busy_q;

	// geometry of the current slot and binning numerators
	always_comb begin
		nx      = geo_nx_q[cur_q.slot];
		ny      = geo_ny_q[cur_q.slot];
		dx      = geo_dx_q[cur_q.slot];
		dy      = geo_dy_q[cur_q.slot];
		sx      = {cur_q.pixel_x[ffcol_pkg::POS_W-1], cur_q.pixel_x} + ffcol_pkg::PAD_X;
		sy      = {cur_q.pixel_y[ffcol_pkg::POS_W-1], cur_q.pixel_y} + ffcol_pkg::PAD_Y;
		px      = 23'(sx) * 23'($signed({1'b0, nx}));
		py      = 23'(sy) * 23'($signed({1'b0, ny}));
		in_grid = ({1'b0, cur_q.cell_col} < nx) && ({1'b0, cur_q.cell_row} < ny);
		wr_corr = (state_q == B_CHECK) && (cur_q.action == ffcol_pkg::ACT_LOAD_CORR) &&
			in_grid;
		div_start = (state_q == B_CHECK) && (cur_q.action == ffcol_pkg::ACT_QUERY);
	end

	// clamp quotients to the grid
	always_comb begin
		nx_m1 = nx - 1'b1;
		ny_m1 = ny - 1'b1;
		if (neg_x_q)
			col_c = '0;
		else if (qx > ffcol_pkg::NUM_W'(nx_m1))
			col_c = nx_m1[ffcol_pkg::CELL_W-1:0];
		else
			col_c = qx[ffcol_pkg::CELL_W-1:0];
		if (neg_y_q)
			row_c = '0;
		else if (qy > ffcol_pkg::NUM_W'(ny_m1))
			row_c = ny_m1[ffcol_pkg::CELL_W-1:0];
		else
			row_c = qy[ffcol_pkg::CELL_W-1:0];
	end

	ffcol_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (px[ffcol_pkg::NUM_W-1:0]),
		.den    (dx),
		.done   (dx_done),
		.quot   (qx)
	);

	ffcol_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (py[ffcol_pkg::NUM_W-1:0]),
		.den    (dy),
		.done   (dy_done),
		.quot   (qy)
	);

	// cell offset memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (clr_busy_q)
			cell_mem[clr_addr_q] <= '0;
		else if (wr_corr)
			cell_mem[{cur_q.slot, cur_q.cell_col, cur_q.cell_row}] <= cur_q.offset_value;
		if (state_q == B_READ)
			mem_rd_q <= cell_mem[{cur_q.slot, col_q, row_q}];
	end

	// geometry table and payload registers
	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= pop_cmd;
		if (state_q == B_IDLE && pop_valid && !clr_busy_q &&
				pop_cmd.action == ffcol_pkg::ACT_LOAD_IMAGE &&
				pop_cmd.status == ffcol_pkg::ST_OK) begin
			geo_nx_q[pop_cmd.slot] <= pop_cmd.cells_across;
			geo_ny_q[pop_cmd.slot] <= pop_cmd.cells_down;
			geo_dx_q[pop_cmd.slot] <= pop_cmd.chip_width;
			geo_dy_q[pop_cmd.slot] <= pop_cmd.chip_height;
		end
		if (div_start) begin
			neg_x_q <= px[22];
			neg_y_q <= py[22];
		end
		if (state_q == B_DIV && dx_done) begin
			col_q <= col_c;
			row_q <= row_c;
		end
		if (state_q == B_EMIT && out_free) begin
			m_tuser_q <= res_status_q;
			m_tdata_q <= res_mem_q ? {row_q, col_q, mem_rd_q} : 24'd0;
		end
	end

	// sequencer, clearing pass and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			clr_busy_q   <= 1'b1;
			clr_addr_q   <= '0;
			m_tvalid_q   <= 1'b0;
			res_status_q <= ffcol_pkg::ST_OK;
			res_mem_q    <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == ffcol_pkg::ADDR_W'(DEPTH - 1))
					clr_busy_q <= 1'b0;
			end
			// result taken; a new one is loaded from B_EMIT instead
			if (m_tvalid_q && m_tready && state_q != B_EMIT)
				m_tvalid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						res_status_q <= pop_cmd.status;
						res_mem_q    <= 1'b0;
						if (pop_cmd.status == ffcol_pkg::ST_OK &&
								(pop_cmd.action == ffcol_pkg::ACT_LOAD_CORR ||
								pop_cmd.action == ffcol_pkg::ACT_QUERY))
							state_q <= B_CHECK;
						else
							state_q <= B_EMIT;
					end
				end
				B_CHECK: begin
					if (cur_q.action == ffcol_pkg::ACT_QUERY) begin
						state_q <= B_DIV;
					end else begin
						if (!in_grid)
							res_status_q <= ffcol_pkg::ST_CELL;
						state_q <= B_EMIT;
					end
				end
				B_DIV: begin
					if (dx_done && dy_done)
						state_q <= B_READ;
				end
				B_READ: begin
					res_mem_q <= 1'b1;
					state_q   <= B_EMIT;
				end
				B_EMIT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/flat_field_cell_offset_lookup.sv
// ----------------------------------------------------------------------------
// flat_field_cell_offset_lookup
// Flat-field correction table with per-cell offsets and pixel binning.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one command per transfer, kind in s_tuser (load image,
//   load correction, query), operands in s_tdata. Output stream m_*: exactly
//   one result per command, status in m_tuser, offset and cell in m_tdata.
//   Commands are handled one at a time by the front end (accept, ID map
//   lookup, classify) and queued into a two-entry queue; the back end
//   executes them in order. A query bins X and Y in parallel with the two
//   20-step bit-serial dividers. The front end can accept further commands
//   while the back end executes earlier ones, until the queue fills.
//   After reset the offset store is cleared, one entry a cycle, over all
//   4096 entries; s_tready stays low until then. When the receiver stalls,
//   the result waits in the output register, the back end holds, the queue
//   fills and s_tready falls.
// ----------------------------------------------------------------------------
`default_nettype none
module flat_field_cell_offset_lookup (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// image_id, pixel_x, pixel_y, cells_across, cells_down, chip_width,
	// chip_height, cell_col, cell_row, offset_value, zero fill
	input  wire logic [111:0] s_tdata,
	// action
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// offset_out, bin_col, bin_row
	output logic [23:0]       m_tdata,
	// status, zero fill
	output logic [7:0]        m_tuser
);

	ffcol_pkg::cmd_t push_cmd;
	ffcol_pkg::cmd_t pop_cmd;
	logic            push_valid;
	logic            push_full;
	logic            pop_valid;
	logic            pop;
	logic            clearing;

	ffcol_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.clearing   (clearing),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push_valid (push_valid),
		.push_full  (push_full),
		.push_cmd   (push_cmd)
	);

	ffcol_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_full  (push_full),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_cmd    (pop_cmd)
	);

	ffcol_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.clearing  (clearing),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_cmd   (pop_cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
`default_nettype wire

// File: rtl/ffcol_checker.sv
// ----------------------------------------------------------------------------
// ffcol_checker
// Port-level checks for the flat-field cell offset lookup.
// ----------------------------------------------------------------------------
`default_nettype none
`include "flat_field_cell_offset_lookup_macros.svh"
module ffcol_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic [111:0] s_tdata,
	input wire logic [1:0]   s_tuser,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [23:0]  m_tdata,
	input wire logic [7:0]   m_tuser
);

	// stalled result holds
	`FFCOL_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

	// errors carry no offset or cell
	`FFCOL_ASSERT_IMPL(a_err_zero, clk, arst_n, m_tvalid && m_tuser[2:0] != 3'(ffcol_pkg::ST_OK), m_tdata == 24'd0, "error result with payload")

	// status code stays in range
	`FFCOL_ASSERT_IMPL(a_status_rng, clk, arst_n, m_tvalid, m_tuser <= 8'(ffcol_pkg::ST_CELL), "bad status code")

	// one command in the front end at a time
	`FFCOL_ASSERT_NEXT(a_one_front, clk, arst_n, s_tvalid && s_tready, !s_tready, "back-to-back accept")

endmodule

bind flat_field_cell_offset_lookup ffcol_checker u_ffcol_checker (.*);
`default_nettype wire
